/* sv/strided_access_interval_merger_defines.svh */
// assertion macros for the strided access interval merger checker
// expects clk and rst in the scope where a macro is used
`ifndef STRIDED_ACCESS_INTERVAL_MERGER_DEFINES_SVH
`define STRIDED_ACCESS_INTERVAL_MERGER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SAM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval merger assertion failed");

// next-cycle implication, checked outside reset
`define SAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval merger assertion failed");

`endif

/* sv/sam_pkg.sv */
// shared types and constants of the strided access interval merger
// no dependencies
package sam_pkg;

  localparam int MAX_REPEATS = 256;
  localparam int IDX_W       = $clog2(MAX_REPEATS);
  localparam int FILL_W      = IDX_W + 1;
  localparam int ADDR_W      = 64;
  localparam int HALF_W      = 16;
  localparam int STEP_W      = 2 * HALF_W;
  localparam int REP_W       = 9;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [IDX_W-1:0]  sid;
  } heap_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    heap_entry_t       wr_data;
  } heap_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [HALF_W-1:0] wr_data;
  } pos_req_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] base_addr;
    logic [HALF_W-1:0] block_count;
    logic [HALF_W-1:0] block_size;
    logic [HALF_W-1:0] block_stride;
    logic [REP_W-1:0]  repeat_count;
    logic [HALF_W-1:0] repeat_stride;
  } req_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic              ok;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_MUL, ST_LD_PUSH, ST_UP, ST_UP_CMP,
    ST_NX_RD, ST_NX_HEAD, ST_NX_POS, ST_DN, ST_DN_CMP, ST_DONE
  } seq_state_t;

endpackage

/* sv/sam_req_if.sv */
// request channel of the interval merger: valid/ready plus descriptor fields
// depends on sam_pkg
interface sam_req_if
  import sam_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] base_addr;
  logic [HALF_W-1:0] block_count;
  logic [HALF_W-1:0] block_size;
  logic [HALF_W-1:0] block_stride;
  logic [REP_W-1:0]  repeat_count;
  logic [HALF_W-1:0] repeat_stride;

  modport source (output valid, command, base_addr, block_count, block_size,
                  block_stride, repeat_count, repeat_stride, input ready);
  modport sink   (input valid, command, base_addr, block_count, block_size,
                  block_stride, repeat_count, repeat_stride, output ready);
endinterface

/* sv/sam_rsp_if.sv */
// result channel of the interval merger: valid/ready plus interval fields
// depends on sam_pkg
interface sam_rsp_if
  import sam_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] interval_start;
  logic [ADDR_W-1:0] interval_end;
  logic              valid_res;

  modport source (output valid, interval_start, interval_end, valid_res, input ready);
  modport sink   (input valid, interval_start, interval_end, valid_res, output ready);
endinterface

/* sv/sam_heap_ram.sv */
// heap storage: one write port, two registered read ports
// depends on sam_pkg
module sam_heap_ram
  import sam_pkg::*;
(
  input  logic        clk,
  input  heap_req_t   req,
  output heap_entry_t rd_data_a,
  output heap_entry_t rd_data_b
);

  heap_entry_t mem [MAX_REPEATS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
    end
  end

endmodule

/* sv/sam_pos_ram.sv */
// per-series block position storage, one write and one registered read
// depends on sam_pkg
module sam_pos_ram
  import sam_pkg::*;
(
  input  logic              clk,
  input  pos_req_t          req,
  output logic [HALF_W-1:0] rd_data
);

  logic [HALF_W-1:0] mem [MAX_REPEATS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

/* sv/sam_seq.sv */
// sequencer: loads descriptors into the heap and merges heap heads
// depends on sam_pkg, sam_heap_ram, sam_pos_ram
module sam_seq
  import sam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_item_t item_in,
  output logic      idle,
  input  logic      out_free,
  output logic      done,
  output result_t   res
);

  seq_state_t        state, state_next;
  logic [ADDR_W-1:0] desc_base;
  logic [HALF_W-1:0] desc_block_count, desc_block_size, desc_block_stride;
  logic [HALF_W-1:0] desc_repeat_stride;
  logic [STEP_W-1:0] bstep, rstep;
  logic [FILL_W-1:0] reps, cnt, fill;
  logic [ADDR_W-1:0] cur_key;
  logic [IDX_W-1:0]  idx;
  heap_entry_t       item, head;
  logic              first;

  heap_req_t         hreq;
  pos_req_t          preq;
  heap_entry_t       rd_a, rd_b;
  logic [HALF_W-1:0] pos_rd;

  sam_heap_ram u_heap (.clk(clk), .req(hreq), .rd_data_a(rd_a), .rd_data_b(rd_b));
  sam_pos_ram  u_pos  (.clk(clk), .req(preq), .rd_data(pos_rd));

  // derived values
  logic [IDX_W-1:0]  parent;
  logic [FILL_W-1:0] lchild;
  logic [FILL_W:0]   rchild;
  logic              l_win, r_win;
  logic [ADDR_W-1:0] best_key;
  logic [ADDR_W-1:0] blk_end, run_base, run_end;
  logic              merge, advance;
  logic [FILL_W-1:0] reps_sat;

  assign parent   = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign lchild   = {idx, 1'b1};
  assign rchild   = {1'b0, lchild} + (FILL_W+1)'(1);
  assign l_win    = (lchild < fill) && (rd_a.key < item.key);
  assign best_key = l_win ? rd_a.key : item.key;
  assign r_win    = (rchild < {1'b0, fill}) && (rd_b.key < best_key);
  assign merge    = first || (rd_a.key <= res.stop);
  assign blk_end  = rd_a.key + ADDR_W'(desc_block_size);
  assign run_base = first ? rd_a.key : res.stop;
  assign run_end  = (blk_end > run_base) ? blk_end : run_base;
  assign advance  = ({1'b0, pos_rd} + (HALF_W+1)'(1)) < {1'b0, desc_block_count};
  assign reps_sat = (int'(item_in.repeat_count) > MAX_REPEATS) ?
                    FILL_W'(MAX_REPEATS) : FILL_W'(item_in.repeat_count);

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (item_in.command == CMD_LOAD) begin
            state_next = ST_LD_MUL;
          end else if (fill == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_NX_RD;
          end
        end
      end
      ST_LD_MUL:  state_next = ST_LD_PUSH;
      ST_LD_PUSH: state_next = (cnt == reps) ? ST_DONE : ST_UP;
      ST_UP:      state_next = (idx == '0) ? ST_LD_PUSH : ST_UP_CMP;
      ST_UP_CMP:  state_next = (rd_a.key <= item.key) ? ST_LD_PUSH : ST_UP;
      ST_NX_RD:   state_next = (fill == '0) ? ST_DONE : ST_NX_HEAD;
      ST_NX_HEAD: state_next = merge ? ST_NX_POS : ST_DONE;
      ST_NX_POS: begin
        if (!advance && fill == FILL_W'(1)) begin
          state_next = ST_NX_RD;
        end else begin
          state_next = ST_DN;
        end
      end
      ST_DN:      state_next = ST_DN_CMP;
      ST_DN_CMP:  state_next = (l_win || r_win) ? ST_DN : ST_NX_RD;
      ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    hreq = '0;
    preq = '0;
    case (state)
      ST_LD_PUSH: begin
        preq.wr_en   = (cnt != reps);
        preq.wr_addr = cnt[IDX_W-1:0];
        preq.wr_data = '0;
      end
      ST_UP: begin
        hreq.rd_en     = 1'b1;
        hreq.rd_addr_a = parent;
        hreq.wr_en     = (idx == '0);
        hreq.wr_addr   = idx;
        hreq.wr_data   = item;
      end
      ST_UP_CMP: begin
        hreq.wr_en   = 1'b1;
        hreq.wr_addr = idx;
        hreq.wr_data = (rd_a.key <= item.key) ? item : rd_a;
      end
      ST_NX_RD: begin
        hreq.rd_en     = 1'b1;
        hreq.rd_addr_a = '0;
      end
      ST_NX_HEAD: begin
        preq.rd_addr   = rd_a.sid;
        hreq.rd_en     = 1'b1;
        hreq.rd_addr_b = IDX_W'(fill - FILL_W'(1));
      end
      ST_NX_POS: begin
        preq.wr_en   = advance;
        preq.wr_addr = head.sid;
        preq.wr_data = pos_rd + HALF_W'(1);
      end
      ST_DN: begin
        hreq.rd_en     = 1'b1;
        hreq.rd_addr_a = lchild[IDX_W-1:0];
        hreq.rd_addr_b = rchild[IDX_W-1:0];
      end
      ST_DN_CMP: begin
        hreq.wr_en   = 1'b1;
        hreq.wr_addr = idx;
        hreq.wr_data = r_win ? rd_b : (l_win ? rd_a : item);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      fill               <= '0;
      desc_base          <= '0;
      desc_block_count   <= '0;
      desc_block_size    <= '0;
      desc_block_stride  <= '0;
      desc_repeat_stride <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            first <= 1'b1;
            if (item_in.command == CMD_LOAD) begin
              res                <= '0;
              desc_base          <= item_in.base_addr;
              desc_block_count   <= item_in.block_count;
              desc_block_size    <= item_in.block_size;
              desc_block_stride  <= item_in.block_stride;
              desc_repeat_stride <= item_in.repeat_stride;
              reps               <= reps_sat;
              cnt                <= '0;
              fill               <= '0;
            end else begin
              res <= '{start: '0, stop: '0, ok: (fill != '0)};
            end
          end
        end
        ST_LD_MUL: begin
          bstep   <= STEP_W'(desc_block_size) * STEP_W'(desc_block_stride);
          rstep   <= STEP_W'(desc_repeat_stride) * STEP_W'(desc_block_size);
          cur_key <= desc_base;
        end
        ST_LD_PUSH: begin
          if (cnt != reps) begin
            item    <= '{key: cur_key, sid: cnt[IDX_W-1:0]};
            idx     <= fill[IDX_W-1:0];
            fill    <= fill + FILL_W'(1);
            cnt     <= cnt + FILL_W'(1);
            cur_key <= cur_key + ADDR_W'(rstep);
          end
        end
        ST_UP_CMP: begin
          if (!(rd_a.key <= item.key)) begin
            idx <= parent;
          end
        end
        ST_NX_HEAD: begin
          if (merge) begin
            res   <= '{start: (first ? rd_a.key : res.start), stop: run_end, ok: res.ok};
            first <= 1'b0;
            head  <= rd_a;
          end
        end
        ST_NX_POS: begin
          idx <= '0;
          if (advance) begin
            item <= '{key: head.key + ADDR_W'(bstep), sid: head.sid};
          end else begin
            // series used up: last entry fills the hole at the root
            fill <= fill - FILL_W'(1);
            item <= rd_b;
          end
        end
        ST_DN_CMP: begin
          if (r_win) begin
            idx <= rchild[IDX_W-1:0];
          end else if (l_win) begin
            idx <= lchild[IDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/strided_access_interval_merger.sv */
// Strided access interval merger: top level with result register.
// Depends on sam_pkg, sam_req_if, sam_rsp_if and sam_seq.
//
// Usage: requests arrive on req (valid/ready). command 0 loads a strided
// descriptor and is answered by one result with valid_res 0; command 1
// answers with the next coalesced interval [interval_start, interval_end)
// or with valid_res 0 once the descriptor is used up. Every request gives
// exactly one result on rsp, in order.
// One request is worked on at a time; req.ready is high only while idle.
// A load pushes each repeat onto the heap and sifts it up; a next request
// takes heap heads while they merge into the interval and sifts the refill
// of the root down. Each sift step reads the heap memory, then compares
// and writes back.
// Results sit in an output register: a new request is taken while an older
// result waits, and the sequencer holds its finished result if rsp stalls.
// Synchronous reset empties the heap and clears the descriptor and rsp.valid.
module strided_access_interval_merger
  import sam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sam_req_if.sink   req,
  sam_rsp_if.source rsp
);

  req_item_t item_in;
  result_t   res, out_q;
  logic      idle, done, out_free, out_valid;

  assign item_in = '{command:       req.command,
                     base_addr:     req.base_addr,
                     block_count:   req.block_count,
                     block_size:    req.block_size,
                     block_stride:  req.block_stride,
                     repeat_count:  req.repeat_count,
                     repeat_stride: req.repeat_stride};

  assign req.ready = idle;
  assign out_free  = !out_valid || rsp.ready;

  sam_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid && idle),
    .item_in  (item_in),
    .idle     (idle),
    .out_free (out_free),
    .done     (done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
      out_q     <= res;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.interval_start = out_q.start;
  assign rsp.interval_end   = out_q.stop;
  assign rsp.valid_res      = out_q.ok;

endmodule

/* sv/sam_checker.sv */
// port-level checks for the interval merger, bound to the top level
// depends on strided_access_interval_merger_defines.svh
`include "strided_access_interval_merger_defines.svh"

module sam_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_valid_res,
  input logic [63:0] rsp_start,
  input logic [63:0] rsp_end
);

  // an empty answer carries zero addresses
  `SAM_ASSERT_IMPL(a_empty_zero, rsp_valid && !rsp_valid_res, rsp_start == 64'd0 && rsp_end == 64'd0)
  // one request at a time
  `SAM_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
  // a stalled result stays offered
  `SAM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  // nothing offered right after reset
  `SAM_ASSERT_IMPL(a_reset_clear, $past(rst), !rsp_valid)

endmodule

bind strided_access_interval_merger sam_checker u_sam_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_valid_res (rsp.valid_res),
  .rsp_start     (rsp.interval_start),
  .rsp_end       (rsp.interval_end)
);
